FILE: src/nearest_neighbour_pcm_resampler_macros.svh
// Assertion macros for the nearest-neighbour PCM resampler checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef NEAREST_NEIGHBOUR_PCM_RESAMPLER_MACROS_SVH
`define NEAREST_NEIGHBOUR_PCM_RESAMPLER_MACROS_SVH

// same-cycle implication
`define NNPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NNPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nnpr_pkg.sv
// Package for the nearest-neighbour PCM resampler: item types, sizes, codes.
// No dependencies.
`timescale 1ns / 1ps

package nnpr_pkg;

  localparam int MAX_SOURCE_WORDS  = 16384;
  localparam int MAX_OUTPUT_FRAMES = 16384;

  localparam int COUNT_W   = 15;
  localparam int ADDR_W    = $clog2(MAX_SOURCE_WORDS);
  localparam int RATE_W    = 18;
  localparam int SAMPLE_W  = 16;
  localparam int DVD_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO_SOURCE  = 2'd0,
    REG_SOURCE_RATE_HZ = 2'd1,
    REG_OUTPUT_RATE_HZ = 2'd2,
    REG_MAX_OUT_FRAMES = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample_word;
    logic                       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_frame;
    logic                       nothing_left;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_res_t;

endpackage

FILE: src/nnpr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nnpr_pkg.
`timescale 1ns / 1ps

module nnpr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [nnpr_pkg::DVD_W-1:0]    dividend,
  input  logic [nnpr_pkg::RATE_W-1:0]   divisor,
  output nnpr_pkg::div_res_t            res
);

  localparam int CNT_W = $clog2(nnpr_pkg::DVD_W);

  logic [nnpr_pkg::DVD_W-1:0]  dvd_r;
  logic [nnpr_pkg::RATE_W-1:0] dsr_r;
  logic [nnpr_pkg::RATE_W-1:0] rem_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [nnpr_pkg::RATE_W:0]   shifted;
  logic [nnpr_pkg::RATE_W:0]   diff;
  logic                        qbit;

  assign shifted = {rem_r, dvd_r[nnpr_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign qbit    = (shifted >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(nnpr_pkg::DVD_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[nnpr_pkg::RATE_W-1:0] : shifted[nnpr_pkg::RATE_W-1:0];
        dvd_r <= {dvd_r[nnpr_pkg::DVD_W-2:0], qbit};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign res.done     = done_r;
  assign res.quotient = dvd_r;

endmodule

FILE: src/nearest_neighbour_pcm_resampler.sv
// Nearest-neighbour PCM resampler, top level. Word store, sequencer, shared multiplier.
// Depends on nnpr_pkg and nnpr_div.
//
// Load items write source words into a 16384-word store; a load that does not
// close a buffer leaves in_ready high. The load that closes a buffer works out
// the output frame count: one multiply, then, given source frames and a nonzero
// divisor, the shared bit-serial divider. A pull takes one multiply, the same
// 32-step divide and one or two store reads; a pull with no frame left goes
// straight to the output stage. in_ready is low while an item is being worked
// on; a finished result waits in the output register while the next item is
// taken. The store is not cleared after reset and needs no clearing pass.
`timescale 1ns / 1ps

module nearest_neighbour_pcm_resampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  nnpr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output nnpr_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnpr_pkg::RATE_W-1:0]       cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CL_MUL, S_CL_WAIT, S_PL_MUL, S_PL_WAIT,
    S_PL_RD0, S_PL_RD1, S_PL_RD2, S_OUT
  } state_t;

  localparam int CW = nnpr_pkg::COUNT_W;
  localparam int AW = nnpr_pkg::ADDR_W;
  localparam int RW = nnpr_pkg::RATE_W;

  state_t                      state_r;
  logic                        stereo_r;
  logic [RW-1:0]               src_rate_r;
  logic [RW-1:0]               dev_rate_r;
  logic [CW-1:0]               max_out_r;
  logic [CW-1:0]               wc_r;
  logic [CW-1:0]               total_r;
  logic [CW-1:0]               idx_r;
  logic                        closed_r;
  logic [CW-1:0]               addr_r;
  nnpr_pkg::out_item_t         res_r;
  nnpr_pkg::out_item_t         out_r;
  logic                        out_valid_r;
  logic [nnpr_pkg::SAMPLE_W-1:0] rdata_r;

  logic [nnpr_pkg::SAMPLE_W-1:0] word_store [nnpr_pkg::MAX_SOURCE_WORDS];

  logic                        in_acc;
  logic [CW-1:0]               nin;
  logic [RW-1:0]               div_sel;
  logic [CW-1:0]               wc_base;
  logic                        we;
  logic [CW-1:0]               mul_a;
  logic [RW-1:0]               mul_b;
  logic [CW+RW-1:0]            prod;
  logic                        cl_ok;
  logic                        div_start;
  logic [RW-1:0]               divisor;
  nnpr_pkg::div_res_t          div_res;
  logic [CW-1:0]               lim;
  logic [CW-1:0]               capped;
  logic [CW:0]                 addr_p1;
  logic [AW-1:0]               rd_addr;
  logic [CW-1:0]               si;
  logic [nnpr_pkg::SAMPLE_W-1:0] rd_word;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign nin     = stereo_r ? (wc_r >> 1) : wc_r;
  assign div_sel = (src_rate_r != '0) ? src_rate_r : dev_rate_r;
  assign wc_base = closed_r ? '0 : wc_r;
  assign we      = in_acc && (in_data.operation == nnpr_pkg::OP_LOAD) &&
                   (wc_base < CW'(nnpr_pkg::MAX_SOURCE_WORDS));

  assign mul_a = (state_r == S_CL_MUL) ? nin : idx_r;
  assign mul_b = (state_r == S_CL_MUL) ? dev_rate_r : RW'(nin);
  assign prod  = (CW+RW)'(mul_a) * (CW+RW)'(mul_b);

  assign cl_ok     = (nin != '0) && (div_sel != '0);
  assign div_start = ((state_r == S_CL_MUL) && cl_ok) || (state_r == S_PL_MUL);
  assign divisor   = (state_r == S_CL_MUL) ? div_sel : RW'(total_r);

  nnpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[nnpr_pkg::DVD_W-1:0]),
    .divisor  (divisor),
    .res      (div_res)
  );

  assign lim    = (max_out_r > CW'(nnpr_pkg::MAX_OUTPUT_FRAMES)) ?
                  CW'(nnpr_pkg::MAX_OUTPUT_FRAMES) : max_out_r;
  assign capped = (div_res.quotient > nnpr_pkg::DVD_W'(lim)) ?
                  lim : div_res.quotient[CW-1:0];
  assign si     = div_res.quotient[CW-1:0];

  assign addr_p1 = {1'b0, addr_r} + 1'b1;
  assign rd_addr = (state_r == S_PL_RD1) ? addr_p1[AW-1:0] : addr_r[AW-1:0];
  assign rd_word = (addr_r < wc_r) ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      word_store[wc_base[AW-1:0]] <= in_data.sample_word;
    end
    rdata_r <= word_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stereo_r    <= 1'b1;
      src_rate_r  <= RW'(48000);
      dev_rate_r  <= RW'(48000);
      max_out_r   <= CW'(16384);
      wc_r        <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          nnpr_pkg::REG_STEREO_SOURCE:  stereo_r   <= cfg_data[0];
          nnpr_pkg::REG_SOURCE_RATE_HZ: src_rate_r <= cfg_data;
          nnpr_pkg::REG_OUTPUT_RATE_HZ: dev_rate_r <= cfg_data;
          nnpr_pkg::REG_MAX_OUT_FRAMES: max_out_r  <= cfg_data[CW-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.operation == nnpr_pkg::OP_LOAD) begin
              if (closed_r) begin
                total_r  <= '0;
                idx_r    <= '0;
                closed_r <= 1'b0;
              end
              wc_r <= wc_base + CW'(we);
              if (in_data.end_of_buffer) begin
                state_r <= S_CL_MUL;
              end
            end else if (!closed_r || idx_r >= total_r) begin
              res_r   <= '{left_sample: '0, right_sample: '0,
                           last_frame: 1'b0, nothing_left: 1'b1};
              state_r <= S_OUT;
            end else begin
              {res_r.last_frame, res_r.nothing_left} <=
                {(({1'b0, idx_r} + 1'b1) == {1'b0, total_r}), 1'b0};
              state_r <= S_PL_MUL;
            end
          end
        end
        S_CL_MUL: begin
          if (cl_ok) begin
            state_r <= S_CL_WAIT;
          end else begin
            total_r  <= '0;
            idx_r    <= '0;
            closed_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_CL_WAIT: begin
          if (div_res.done) begin
            total_r  <= capped;
            idx_r    <= '0;
            closed_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_PL_MUL: begin
          state_r <= S_PL_WAIT;
        end
        S_PL_WAIT: begin
          if (div_res.done) begin
            addr_r  <= stereo_r ? {si[CW-2:0], 1'b0} : si;
            idx_r   <= idx_r + 1'b1;
            state_r <= S_PL_RD0;
          end
        end
        S_PL_RD0: begin
          state_r <= S_PL_RD1;
        end
        S_PL_RD1: begin
          if (stereo_r) begin
            res_r.left_sample <= rd_word;
            state_r           <= S_PL_RD2;
          end else begin
            {res_r.left_sample, res_r.right_sample} <= {rd_word, rd_word};
            state_r                                 <= S_OUT;
          end
        end
        S_PL_RD2: begin
          res_r.right_sample <= (addr_p1 < {1'b0, wc_r}) ? rdata_r : '0;
          state_r            <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/nnpr_checker.sv
// Port-level checker for the nearest-neighbour PCM resampler, bound to the top level.
// Depends on nnpr_pkg and nearest_neighbour_pcm_resampler_macros.svh.
`timescale 1ns / 1ps
`include "nearest_neighbour_pcm_resampler_macros.svh"

module nnpr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input nnpr_pkg::in_item_t             in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input nnpr_pkg::out_item_t            out_data
);

  logic load_acc;
  logic pull_acc;

  assign load_acc = in_valid && in_ready && (in_data.operation == nnpr_pkg::OP_LOAD);
  assign pull_acc = in_valid && in_ready && (in_data.operation == nnpr_pkg::OP_PULL);

  `NNPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item dropped or changed while stalled")
  `NNPR_ASSERT_NOW(a_empty_zero, out_valid && out_data.nothing_left, out_data.left_sample == 0 && out_data.right_sample == 0 && !out_data.last_frame, "empty result item carries data")
  `NNPR_ASSERT_NEXT(a_load_silent, load_acc && !out_valid, !out_valid, "load item produced a result")
  `NNPR_ASSERT_NEXT(a_pull_busy, pull_acc, !in_ready, "pull item finished in one cycle")

endmodule

bind nearest_neighbour_pcm_resampler nnpr_checker u_nnpr_checker (.*);

FILE: verif/nearest_neighbour_pcm_resampler_checker.sv
// Checker for nearest_neighbour_pcm_resampler: watches the item, result and register
// channels, predicts each pulled frame and compares it with the block's result.
// Depends on nnpr_pkg.
`timescale 1ns / 1ps

module nearest_neighbour_pcm_resampler_checker
  import nnpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   frames_owed
);

  logic [SAMPLE_W-1:0] src_words [MAX_SOURCE_WORDS];
  int unsigned         n_words;
  int unsigned         n_frames_out;
  int unsigned         frame_idx;
  bit                  closed;

  bit                  stereo;
  int unsigned         src_rate;
  int unsigned         dev_rate;
  int unsigned         max_frames;

  out_item_t           frames_due[$];
  int                  fault_count = 0;

  assign mismatches = fault_count;

  function automatic longint unsigned source_frames();
    return stereo ? longint'(n_words >> 1) : longint'(n_words);
  endfunction

  function automatic void seal_buffer();
    longint unsigned nin;
    longint unsigned divisor;
    longint unsigned nout;
    nin     = source_frames();
    divisor = (src_rate != 0) ? src_rate : dev_rate;
    nout    = 0;
    if (nin != 0 && divisor != 0)
      nout = (nin * longint'(dev_rate)) / divisor;
    if (nout > max_frames)
      nout = max_frames;
    if (nout > MAX_OUTPUT_FRAMES)
      nout = MAX_OUTPUT_FRAMES;
    n_frames_out = int'(nout);
    frame_idx    = 0;
    closed       = 1'b1;
  endfunction

  function automatic void store_word(logic [SAMPLE_W-1:0] word, logic eob);
    // a load after close starts a fresh buffer
    if (closed) begin
      n_words      = 0;
      n_frames_out = 0;
      frame_idx    = 0;
      closed       = 1'b0;
    end
    if (n_words < MAX_SOURCE_WORDS) begin
      src_words[n_words] = word;
      n_words++;
    end
    if (eob)
      seal_buffer();
  endfunction

  function automatic out_item_t pull_frame();
    out_item_t       f;
    longint unsigned nin;
    longint unsigned si;
    longint unsigned pos;
    f = '0;
    if (!closed || frame_idx >= n_frames_out) begin
      f.nothing_left = 1'b1;
      return f;
    end
    nin = source_frames();
    si  = (longint'(frame_idx) * nin) / n_frames_out;
    if (stereo) begin
      pos = si * 2;
      if (pos < n_words)
        f.left_sample = src_words[pos];
      if (pos + 1 < n_words)
        f.right_sample = src_words[pos + 1];
    end else begin
      if (si < n_words)
        f.left_sample = src_words[si];
      f.right_sample = f.left_sample;
    end
    f.last_frame = (frame_idx + 1 == n_frames_out);
    frame_idx++;
    return f;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stereo       = 1'b1;
      src_rate     = 48000;
      dev_rate     = 48000;
      max_frames   = 16384;
      n_words      = 0;
      n_frames_out = 0;
      frame_idx    = 0;
      closed       = 1'b0;
      frames_due.delete();
      frames_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEREO_SOURCE:  stereo     = cfg_data[0];
          REG_SOURCE_RATE_HZ: src_rate   = cfg_data;
          REG_OUTPUT_RATE_HZ: dev_rate   = cfg_data;
          REG_MAX_OUT_FRAMES: max_frames = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_PULL)
          frames_due.push_back(pull_frame());
        else
          store_word(in_data.sample_word, in_data.end_of_buffer);
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          note_fault($sformatf("unexpected frame L=%0d R=%0d last=%0b empty=%0b",
                               out_data.left_sample, out_data.right_sample,
                               out_data.last_frame, out_data.nothing_left));
        end else begin
          out_item_t want;
          want = frames_due.pop_front();
          if (out_data.left_sample !== want.left_sample ||
              out_data.right_sample !== want.right_sample ||
              out_data.last_frame !== want.last_frame ||
              out_data.nothing_left !== want.nothing_left)
            note_fault($sformatf({"frame mismatch: expected L=%0d R=%0d last=%0b empty=%0b,",
                                  " got L=%0d R=%0d last=%0b empty=%0b"},
                                 want.left_sample, want.right_sample,
                                 want.last_frame, want.nothing_left,
                                 out_data.left_sample, out_data.right_sample,
                                 out_data.last_frame, out_data.nothing_left));
        end
      end
      frames_owed <= frames_due.size();
    end
  end

endmodule

FILE: verif/nearest_neighbour_pcm_resampler_test.sv
// Testbench top for nearest_neighbour_pcm_resampler: drives load and pull items,
// register writes and result back-pressure, and gives the verdict.
// Depends on nnpr_pkg, nearest_neighbour_pcm_resampler_checker and the RTL.
`timescale 1ns / 1ps

module nearest_neighbour_pcm_resampler_test;
  import nnpr_pkg::*;

  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASE_ITEMS     = 200;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEREO_SOURCE;
  logic [RATE_W-1:0]    cfg_data  = '0;

  int mismatches;
  int frames_owed;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int sent        = 0;
  int quiet_cycles = 0;
  bit hold_req    = 1'b0;

  logic              cur_stereo;
  logic [RATE_W-1:0] cur_src;
  logic [RATE_W-1:0] cur_out;
  logic [RATE_W-1:0] cur_max;

  always #2 clk = ~clk;

  nearest_neighbour_pcm_resampler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nearest_neighbour_pcm_resampler_checker frame_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .frames_owed (frames_owed)
  );

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic load_word(input logic [SAMPLE_W-1:0] word, input logic eob);
    in_item_t item;
    item.operation     = OP_LOAD;
    item.sample_word   = word;
    item.end_of_buffer = eob;
    send_item(item);
  endtask

  task automatic request_frame();
    in_item_t item;
    item.operation     = OP_PULL;
    item.sample_word   = 16'($urandom);
    item.end_of_buffer = 1'($urandom);
    send_item(item);
  endtask

  // stop offering items and wait until every frame owed has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [RATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic stereo, input logic [RATE_W-1:0] src,
                           input logic [RATE_W-1:0] outr, input logic [RATE_W-1:0] maxf);
    write_reg(REG_STEREO_SOURCE, RATE_W'(stereo));
    write_reg(REG_SOURCE_RATE_HZ, src);
    write_reg(REG_OUTPUT_RATE_HZ, outr);
    write_reg(REG_MAX_OUT_FRAMES, maxf);
    cfg_valid  <= 1'b0;
    cur_stereo = stereo;
    cur_src    = src;
    cur_out    = outr;
    cur_max    = maxf;
  endtask

  task automatic random_settings();
    logic [RATE_W-1:0] src;
    logic [RATE_W-1:0] outr;
    logic [RATE_W-1:0] maxf;
    case ($urandom_range(0, 5))
      0:       src = 0;
      1:       src = 192000;
      2:       src = 48000;
      3:       src = 44100;
      default: src = RATE_W'($urandom_range(1, 192000));
    endcase
    case ($urandom_range(0, 4))
      0:       outr = 1;
      1:       outr = 192000;
      2:       outr = 48000;
      default: outr = RATE_W'($urandom_range(1, 192000));
    endcase
    case ($urandom_range(0, 5))
      0:       maxf = 0;
      1:       maxf = 16384;
      default: maxf = RATE_W'($urandom_range(1, 40));
    endcase
    configure(1'($urandom), src, outr, maxf);
  endtask

  task automatic run_phase(input int budget);
    int       start;
    int       n;
    in_item_t junk;
    start = sent;
    while (sent - start < budget) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: random items in any order
        repeat ($urandom_range(1, 6)) begin
          junk = in_item_t'($urandom);
          send_item(junk);
        end
      end else begin
        if ($urandom_range(0, 99) < 35) begin
          drain();
          random_settings();
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
          load_word(16'($urandom), i == n - 1);
        if ($urandom_range(0, 99) < 15) begin
          // mode change while the buffer is closed
          drain();
          configure(~cur_stereo, cur_src, cur_out, cur_max);
        end
        repeat ($urandom_range(0, 20)) request_frame();
        if ($urandom_range(0, 99) < 20)
          drain();
      end
    end
  endtask

  initial begin
    tx_idle_pct = 38;
    rx_idle_pct = 51;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    configure(1'b1, 48000, 48000, 16384);
    request_frame();
    load_word(16'h7FFF, 1'b0);
    load_word(16'h8000, 1'b0);
    load_word(16'hFFFF, 1'b0);
    load_word(16'h0000, 1'b0);
    load_word(16'h5555, 1'b1);
    repeat (3) request_frame();
    load_word(16'h1234, 1'b1);
    request_frame();
    drain();
    configure(1'b0, 96000, 192000, 3);
    load_word(16'h8000, 1'b0);
    load_word(16'h7FFF, 1'b1);
    repeat (4) request_frame();
    drain();
    configure(1'b0, 0, 192000, 16384);
    load_word(16'hA5A5, 1'b0);
    load_word(16'h5A5A, 1'b0);
    load_word(16'h0001, 1'b1);
    drain();
    configure(1'b1, 0, 192000, 16384);
    repeat (3) request_frame();
    drain();
    configure(1'b1, 48000, 1, 0);
    load_word(16'h4000, 1'b0);
    load_word(16'hC000, 1'b1);
    request_frame();

    run_phase(PHASE_ITEMS);
    drain();
    tx_idle_pct = 51;
    rx_idle_pct = 38;
    run_phase(PHASE_ITEMS);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // back-pressure: results held off while pulls keep coming
    configure(1'b1, 44100, 48000, 40);
    for (int i = 0; i < 8; i++)
      load_word(16'($urandom), i == 7);
    hold_req = 1'b1;
    repeat (8) request_frame();
    drain();

    run_phase(PHASE_ITEMS);
    drain();

    if (mismatches == 0 && frames_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/nnpr_pkg.sv
src/nnpr_div.sv
src/nearest_neighbour_pcm_resampler.sv
src/nnpr_checker.sv
verif/nearest_neighbour_pcm_resampler_checker.sv
verif/nearest_neighbour_pcm_resampler_test.sv
